// ===== rtl/core/tkrt_pkg.sv =====
// ----------------------------------------------------------------------------
// tkrt_pkg: shared types and a helper for the two-key record table
// Holds request codes, controller states, the stored record layout and the
// command/status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package tkrt_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned PlateW          = 32;
  localparam int unsigned BrandW          = 64;
  localparam int unsigned HandleW         = 16;
  localparam int unsigned CountOutW       = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_CLEAR,
    ST_SEARCH,
    ST_SHIFT
  } state_e;

  typedef struct packed {
    logic [PlateW-1:0]  plate;
    logic [BrandW-1:0]  brand;
    logic [HandleW-1:0] handle;
  } record_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;         // capture request, rewind the read pointer
    logic scan;         // run the read pipeline over the table
    logic shift;        // move each read record down one slot
    logic ins;          // append the captured record
    logic clr;          // empty the table
    logic dec;          // drop one record from the count
    logic finish;       // register the result and strobe it
    logic ok;           // success flag of the result
    logic take_handle;  // report the handle of the compared record
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic full;       // table holds CAPACITY records
    logic hit;        // compared record matches both keys
    logic miss;       // nothing left to compare and no hit
    logic shift_end;  // no record pending in the read pipeline
  } dp_sts_t;

  // Keep the bytes up to the first zero byte, clear every byte after it.
  function automatic logic [BrandW-1:0] brand_canon(input logic [BrandW-1:0] b);
    logic [BrandW-1:0] kept;
    logic              live;
    kept = '0;
    live = 1'b1;
    for (int k = 0; k < BrandW / 8; k++) begin
      if (b[8*k +: 8] == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        kept[8*k +: 8] = b[8*k +: 8];
      end
    end
    return kept;
  endfunction

endpackage

// ===== rtl/core/two_key_record_table.sv =====
// ----------------------------------------------------------------------------
// two_key_record_table: bounded record table searched by plate and brand
// Insert appends, query returns the handle of the first record matching both
// keys, remove deletes that record and closes the gap, clear empties it.
//
//   channel | ports                                           | handshake
//   --------+-------------------------------------------------+-------------------
//   request | action_i key_plate_i key_brand_i entry_handle_i | start_i && !busy_o
//   result  | success_o found_handle_o entry_count_o          | done_o, one cycle
//
// A query reads the held records in slot order until a hit or the last one; a
//   remove finds its record that way, then moves each later record down one
//   slot to close the gap before its result shows.
//   The single read port of the record memory reads one record per cycle.
// Reset clears the entry count; record contents stay undefined until written.
// The receiver cannot stall: done_o lasts one cycle with busy_o already low.
// ----------------------------------------------------------------------------
module two_key_record_table #(
  parameter int unsigned CAPACITY = tkrt_pkg::CapacityDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request transaction
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     action_i,
  input  logic [tkrt_pkg::PlateW-1:0]    key_plate_i,
  input  logic [tkrt_pkg::BrandW-1:0]    key_brand_i,
  input  logic [tkrt_pkg::HandleW-1:0]   entry_handle_i,
  // result transaction
  output logic                           done_o,
  output logic                           success_o,
  output logic [tkrt_pkg::HandleW-1:0]   found_handle_o,
  output logic [tkrt_pkg::CountOutW-1:0] entry_count_o
);

  tkrt_pkg::ctrl_cmd_t cmd;
  tkrt_pkg::dp_sts_t   sts;

  // Sequence each request: latch it, then insert, clear, or search and shift.
  tkrt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (tkrt_pkg::action_e'(action_i)),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Hold the records and the count; compare one record per cycle.
  tkrt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .key_plate_i    (key_plate_i),
    .key_brand_i    (key_brand_i),
    .entry_handle_i (entry_handle_i),
    .done_o         (done_o),
    .success_o      (success_o),
    .found_handle_o (found_handle_o),
    .entry_count_o  (entry_count_o)
  );

`ifndef NO_ASSERTIONS
  // A result only shows once the sequencer is back at rest.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobed while a request is in flight");

  // An accepted request always leaves the sequencer busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not make the block busy");

  // Never append to a full table.
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |-> !sts.full)
    else $error("insert issued into a full table");

  // A failed request reports no handle.
  a_fail_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !success_o) |-> (found_handle_o == '0))
    else $error("failed request reported a handle");
`endif

endmodule

// ===== rtl/core/tkrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkrt_ctrl: request sequencer of the two-key record table
// Steps each request through insert, clear, search and shift phases and
// commands the datapath.
// ----------------------------------------------------------------------------
module tkrt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tkrt_pkg::action_e     action_i,
  input  tkrt_pkg::dp_sts_t     sts_i,
  output tkrt_pkg::ctrl_cmd_t   cmd_o,
  output logic                  busy_o
);

  tkrt_pkg::state_e  state_q, state_d;
  tkrt_pkg::action_e act_q, act_d;

  logic accept;

  assign accept = start_i && (state_q == tkrt_pkg::ST_IDLE);
  assign busy_o = (state_q != tkrt_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tkrt_pkg::ST_IDLE;
      act_q   <= tkrt_pkg::ACT_INSERT;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
    end
  end

  assign act_d = accept ? action_i : act_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tkrt_pkg::ST_IDLE: begin
        if (start_i) begin
          unique case (action_i)
            tkrt_pkg::ACT_INSERT: state_d = tkrt_pkg::ST_INSERT;
            tkrt_pkg::ACT_CLEAR:  state_d = tkrt_pkg::ST_CLEAR;
            default:              state_d = tkrt_pkg::ST_SEARCH;
          endcase
        end
      end
      tkrt_pkg::ST_INSERT: state_d = tkrt_pkg::ST_IDLE;
      tkrt_pkg::ST_CLEAR:  state_d = tkrt_pkg::ST_IDLE;
      tkrt_pkg::ST_SEARCH: begin
        if (sts_i.hit) begin
          state_d = (act_q == tkrt_pkg::ACT_REMOVE) ? tkrt_pkg::ST_SHIFT
                                                    : tkrt_pkg::ST_IDLE;
        end else if (sts_i.miss) begin
          state_d = tkrt_pkg::ST_IDLE;
        end
      end
      tkrt_pkg::ST_SHIFT: begin
        if (sts_i.shift_end) begin
          state_d = tkrt_pkg::ST_IDLE;
        end
      end
      default: state_d = tkrt_pkg::ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o      = '0;
    cmd_o.load = accept;
    unique case (state_q)
      tkrt_pkg::ST_INSERT: begin
        cmd_o.ins    = !sts_i.full;
        cmd_o.finish = 1'b1;
        cmd_o.ok     = !sts_i.full;
      end
      tkrt_pkg::ST_CLEAR: begin
        cmd_o.clr    = 1'b1;
        cmd_o.finish = 1'b1;
        cmd_o.ok     = 1'b1;
      end
      tkrt_pkg::ST_SEARCH: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          if (act_q != tkrt_pkg::ACT_REMOVE) begin
            cmd_o.finish      = 1'b1;
            cmd_o.ok          = 1'b1;
            cmd_o.take_handle = 1'b1;
          end
        end else if (sts_i.miss) begin
          cmd_o.finish = 1'b1;
        end
      end
      tkrt_pkg::ST_SHIFT: begin
        cmd_o.scan  = 1'b1;
        cmd_o.shift = 1'b1;
        if (sts_i.shift_end) begin
          cmd_o.dec    = 1'b1;
          cmd_o.finish = 1'b1;
          cmd_o.ok     = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/tkrt_dp.sv =====
// ----------------------------------------------------------------------------
// tkrt_dp: record store and compare datapath of the two-key record table
// Holds the record memory, the entry count, the scan pipeline and the
// result registers.
// ----------------------------------------------------------------------------
module tkrt_dp #(
  parameter int unsigned CAPACITY = tkrt_pkg::CapacityDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tkrt_pkg::ctrl_cmd_t                  cmd_i,
  output tkrt_pkg::dp_sts_t                    sts_o,
  input  logic [tkrt_pkg::PlateW-1:0]          key_plate_i,
  input  logic [tkrt_pkg::BrandW-1:0]          key_brand_i,
  input  logic [tkrt_pkg::HandleW-1:0]         entry_handle_i,
  output logic                                 done_o,
  output logic                                 success_o,
  output logic [tkrt_pkg::HandleW-1:0]         found_handle_o,
  output logic [tkrt_pkg::CountOutW-1:0]       entry_count_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OutW = tkrt_pkg::CountOutW;
  localparam logic [CW-1:0] One = CW'(1);
  localparam logic [CW-1:0] Cap = CW'(CAPACITY);

  tkrt_pkg::record_t mem_q [CAPACITY];
  tkrt_pkg::record_t key_q;
  tkrt_pkg::record_t rd_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cmp_ptr_q, cmp_ptr_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic          done_q;
  logic          success_q;
  logic [tkrt_pkg::HandleW-1:0] found_q;
  logic [OutW-1:0]              count_out_q;

  logic          issue;
  logic          hit;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] shift_dst;
  tkrt_pkg::record_t wr_data;

  assign issue     = cmd_i.scan && (rd_ptr_q < count_q);
  assign hit       = cmp_vld_q && (rd_q.plate == key_q.plate) && (rd_q.brand == key_q.brand);
  assign shift_dst = cmp_ptr_q - One;

  assign sts_o.full      = (count_q >= Cap);
  assign sts_o.hit       = hit;
  assign sts_o.miss      = !issue && !hit;
  assign sts_o.shift_end = !cmp_vld_q;

  // Capture the request; brands are kept in canonical form.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q.plate  <= key_plate_i;
      key_q.brand  <= tkrt_pkg::brand_canon(key_brand_i);
      key_q.handle <= entry_handle_i;
    end
  end

  // Memory write: append on insert, move down on shift.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[AW-1:0];
    wr_data = key_q;
    if (cmd_i.ins) begin
      wr_en = 1'b1;
    end else if (cmd_i.shift && cmp_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = shift_dst[AW-1:0];
      wr_data = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= mem_q[rd_ptr_q[AW-1:0]];
    end
  end

  // Scan pipeline and count.
  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    cmp_ptr_d = cmp_ptr_q;
    cmp_vld_d = cmp_vld_q;
    if (cmd_i.load) begin
      rd_ptr_d  = '0;
      cmp_vld_d = 1'b0;
    end else if (cmd_i.scan) begin
      cmp_vld_d = issue;
      if (issue) begin
        cmp_ptr_d = rd_ptr_q;
        rd_ptr_d  = rd_ptr_q + One;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clr) begin
      count_d = '0;
    end else if (cmd_i.ins) begin
      count_d = count_q + One;
    end else if (cmd_i.dec) begin
      count_d = count_q - One;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_ptr_q  <= '0;
      cmp_ptr_q <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      count_q   <= count_d;
      rd_ptr_q  <= rd_ptr_d;
      cmp_ptr_q <= cmp_ptr_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= cmd_i.finish;
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      success_q   <= cmd_i.ok;
      found_q     <= cmd_i.take_handle ? rd_q.handle : '0;
      count_out_q <= OutW'(count_d);
    end
  end

  assign done_o         = done_q;
  assign success_o      = success_q;
  assign found_handle_o = found_q;
  assign entry_count_o  = count_out_q;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-key record table
// Drives insert, query, remove and clear commands through the start/busy
// handshake, mirrors the table in a behavioral shadow, and checks each
// done-strobed result field by field against the shadow's answer, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PlateW     = tkrt_pkg::PlateW;
  localparam int unsigned BrandW     = tkrt_pkg::BrandW;
  localparam int unsigned HandleW    = tkrt_pkg::HandleW;
  localparam int unsigned CountOutW  = tkrt_pkg::CountOutW;
  localparam int unsigned Capacity   = tkrt_pkg::CapacityDefault;
  localparam int unsigned RandItems  = 2000;
  localparam int unsigned NumPhases  = 4;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned PrintCap   = 40;

  // One request transaction as the sender sees it.
  typedef struct {
    tkrt_pkg::action_e  act;
    logic [PlateW-1:0]  plate;
    logic [BrandW-1:0]  brand;
    logic [HandleW-1:0] handle;
  } request_t;

  // One result transaction: what the table answers to a request.
  typedef struct {
    logic                 success;
    logic [HandleW-1:0]   found;
    logic [CountOutW-1:0] count;
  } answer_t;

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [1:0]           action_i;
  logic [PlateW-1:0]    key_plate_i;
  logic [BrandW-1:0]    key_brand_i;
  logic [HandleW-1:0]   entry_handle_i;
  logic                 done_o;
  logic                 success_o;
  logic [HandleW-1:0]   found_handle_o;
  logic [CountOutW-1:0] entry_count_o;

  two_key_record_table #(
    .CAPACITY(Capacity)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .key_plate_i   (key_plate_i),
    .key_brand_i   (key_brand_i),
    .entry_handle_i(entry_handle_i),
    .done_o        (done_o),
    .success_o     (success_o),
    .found_handle_o(found_handle_o),
    .entry_count_o (entry_count_o)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  request_t pending_q[$];   // commands waiting for the driver
  answer_t  answer_q[$];    // answers owed by the table, oldest first

  // Shadow copy of the table contents.
  logic [PlateW-1:0]  rec_plate [Capacity];
  logic [BrandW-1:0]  rec_brand [Capacity];
  logic [HandleW-1:0] rec_handle[Capacity];
  int unsigned        rec_count;

  int unsigned idle_pct;      // chance in a hundred that the sender idles
  logic        req_taken;     // command on the ports was accepted last edge
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned act_seen[4];
  int unsigned key_hits;      // queries and removes that found a record
  int unsigned full_rejects;  // inserts turned away by a full table
  int unsigned peak_count;

  // Key pools keep hits frequent; brand pool lengths mark where the text ends.
  logic [PlateW-1:0] plate_pool[4];
  logic [BrandW-1:0] brand_pool[5];
  int unsigned       brand_len [5];

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    if (mismatches <= PrintCap) begin
      $display("[%0t] %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
  endtask

  // Brand text ends at the first zero byte; drop everything from there up.
  function automatic logic [BrandW-1:0] brand_text(input logic [BrandW-1:0] b);
    int unsigned cut;
    cut = BrandW / 8;
    for (int k = BrandW / 8 - 1; k >= 0; k--) begin
      if (b[8*k +: 8] == 8'h00) begin
        cut = k;
      end
    end
    if (cut == BrandW / 8) begin
      return b;
    end
    return b & ((64'h1 << (8 * cut)) - 64'h1);
  endfunction

  // Apply one command to the shadow table and return the answer it owes.
  function automatic answer_t apply_request(input request_t req);
    answer_t          ans;
    int               hit;
    logic [BrandW-1:0] want;
    ans  = '{success: 1'b0, found: '0, count: '0};
    hit  = -1;
    want = brand_text(req.brand);
    if (req.act == tkrt_pkg::ACT_QUERY || req.act == tkrt_pkg::ACT_REMOVE) begin
      for (int i = 0; i < int'(rec_count); i++) begin
        if (hit < 0 && rec_plate[i] == req.plate && brand_text(rec_brand[i]) == want) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        key_hits++;
      end
    end
    case (req.act)
      tkrt_pkg::ACT_INSERT: begin
        if (rec_count < Capacity) begin
          rec_plate[rec_count]  = req.plate;
          rec_brand[rec_count]  = req.brand;
          rec_handle[rec_count] = req.handle;
          rec_count++;
          ans.success = 1'b1;
        end else begin
          full_rejects++;
        end
      end
      tkrt_pkg::ACT_QUERY: begin
        if (hit >= 0) begin
          ans.success = 1'b1;
          ans.found   = rec_handle[hit];
        end
      end
      tkrt_pkg::ACT_REMOVE: begin
        if (hit >= 0) begin
          // close the gap: every later record moves down one slot
          for (int j = hit; j + 1 < int'(rec_count); j++) begin
            rec_plate[j]  = rec_plate[j+1];
            rec_brand[j]  = rec_brand[j+1];
            rec_handle[j] = rec_handle[j+1];
          end
          rec_count--;
          ans.success = 1'b1;
        end
      end
      default: begin
        rec_count   = 0;
        ans.success = 1'b1;
      end
    endcase
    if (rec_count > peak_count) begin
      peak_count = rec_count;
    end
    ans.count = CountOutW'(rec_count);
    return ans;
  endfunction

  task automatic push_item(input tkrt_pkg::action_e act, input logic [PlateW-1:0] plate,
                           input logic [BrandW-1:0] brand,
                           input logic [HandleW-1:0] handle);
    request_t req;
    req.act    = act;
    req.plate  = plate;
    req.brand  = brand;
    req.handle = handle;
    pending_q.push_back(req);
  endtask

  // Random command: mostly keys from the pools so that queries and removes
  // find records, with junk after the brand's terminator to exercise the
  // string compare, and a tenth of fully random keys as noise.
  function automatic request_t random_request();
    request_t          req;
    int unsigned       r;
    int unsigned       b;
    logic [BrandW-1:0] junk;
    r = $urandom_range(99);
    if (r < 42) begin
      req.act = tkrt_pkg::ACT_INSERT;
    end else if (r < 70) begin
      req.act = tkrt_pkg::ACT_QUERY;
    end else if (r < 96) begin
      req.act = tkrt_pkg::ACT_REMOVE;
    end else begin
      req.act = tkrt_pkg::ACT_CLEAR;
    end
    req.handle = HandleW'($urandom);
    if ($urandom_range(9) == 0) begin
      req.plate = $urandom;
      req.brand = {$urandom, $urandom};
    end else begin
      req.plate = plate_pool[$urandom_range(3)];
      b         = $urandom_range(4);
      req.brand = brand_pool[b];
      // fill bytes past the terminator with garbage half of the time
      if (brand_len[b] < 7 && $urandom_range(1) == 1) begin
        junk      = {$urandom, $urandom};
        req.brand = req.brand | (junk & ~((64'h1 << (8 * (brand_len[b] + 1))) - 64'h1));
      end
    end
    return req;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: change inputs at the falling edge. Hold a command until the
  // monitor saw it taken, then advance to the next one or idle.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    request_t nxt;
    if (rst_ni && (!start_i || req_taken)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_q.pop_front();
        start_i        <= 1'b1;
        action_i       <= nxt.act;
        key_plate_i    <= nxt.plate;
        key_brand_i    <= nxt.brand;
        entry_handle_i <= nxt.handle;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample at the rising edge. Check the result first, since a new
  // command may be accepted in the same cycle that the previous answer shows.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    answer_t  want;
    request_t req;
    if (rst_ni) begin
      if (done_o) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          report_mismatch("result with no command pending", 64'(results_seen), 64'(0));
        end else begin
          want = answer_q.pop_front();
          if (success_o !== want.success) begin
            report_mismatch("success", 64'(success_o), 64'(want.success));
          end
          if (found_handle_o !== want.found) begin
            report_mismatch("found_handle", 64'(found_handle_o), 64'(want.found));
          end
          if (entry_count_o !== want.count) begin
            report_mismatch("entry_count", 64'(entry_count_o), 64'(want.count));
          end
        end
      end
      if (start_i && !busy_o) begin
        req.act    = tkrt_pkg::action_e'(action_i);
        req.plate  = key_plate_i;
        req.brand  = key_brand_i;
        req.handle = entry_handle_i;
        act_seen[action_i]++;
        answer_q.push_back(apply_request(req));
      end
      req_taken <= start_i && !busy_o;
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("two_key_record_table: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_idle[NumPhases];
    // no idling, sender mostly idle, no idling again, light sender idling
    phase_idle    = '{0, 82, 0, 8};
    plate_pool    = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_1234};
    brand_pool    = '{64'h0, 64'h41, 64'h4452_4F46, 64'h534E_454F_5254_4943,
                      64'hFFFF_FFFF_FFFF_FFFF};
    brand_len     = '{0, 1, 4, 8, 8};
    start_i        = 1'b0;
    action_i       = tkrt_pkg::ACT_INSERT;
    key_plate_i    = '0;
    key_brand_i    = '0;
    entry_handle_i = '0;
    req_taken      = 1'b0;
    idle_pct       = 0;
    cycles         = 0;
    mismatches     = 0;
    results_seen   = 0;
    act_seen       = '{0, 0, 0, 0};
    key_hits       = 0;
    full_rejects   = 0;
    peak_count     = 0;
    rec_count      = 0;

    // Directed: empty table corners, extreme keys, brand terminator
    // handling, first-match order, remove from the front, fill past full.
    push_item(tkrt_pkg::ACT_CLEAR,  32'h0,         64'h0,                   16'h0);
    push_item(tkrt_pkg::ACT_QUERY,  32'h0,         64'h0,                   16'h0);
    push_item(tkrt_pkg::ACT_REMOVE, 32'h0,         64'h0,                   16'h0);
    push_item(tkrt_pkg::ACT_INSERT, 32'h0,         64'h0,                   16'h0);
    push_item(tkrt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    push_item(tkrt_pkg::ACT_INSERT, 32'h5,         64'hA5C3_7E11_9900_4241, 16'h1234);
    push_item(tkrt_pkg::ACT_INSERT, 32'h5,         64'h1122_3344_5500_4241, 16'h5678);
    push_item(tkrt_pkg::ACT_QUERY,  32'h5,         64'h4241,                16'hAAAA);
    push_item(tkrt_pkg::ACT_QUERY,  32'h0,         64'hFFFF_FFFF_FFFF_FF00, 16'h0);
    push_item(tkrt_pkg::ACT_QUERY,  32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
    push_item(tkrt_pkg::ACT_QUERY,  32'h5,         64'h4341,                16'h0);
    push_item(tkrt_pkg::ACT_REMOVE, 32'h5,         64'h4241,                16'h0);
    push_item(tkrt_pkg::ACT_QUERY,  32'h5,         64'h0000_0000_0000_4241, 16'h0);
    push_item(tkrt_pkg::ACT_REMOVE, 32'h0,         64'h0,                   16'h0);
    for (int i = 0; i < 15; i++) begin
      push_item(tkrt_pkg::ACT_INSERT, 32'h100 + i, 64'h4452_4F46, 16'(16'h0A00 + i));
    end
    push_item(tkrt_pkg::ACT_REMOVE, 32'h10D, 64'h4452_4F46, 16'h0);
    push_item(tkrt_pkg::ACT_CLEAR,  32'h0,   64'h0,         16'h0);

    for (int p = 0; p < NumPhases; p++) begin
      // hold off until the previous batch has been fully answered
      while (pending_q.size() > 0 || start_i || answer_q.size() > 0) begin
        @(posedge clk_i);
      end
      idle_pct = phase_idle[p];
      for (int n = 0; n < RandItems / NumPhases; n++) begin
        pending_q.push_back(random_request());
      end
    end

    while (pending_q.size() > 0 || start_i || answer_q.size() > 0) begin
      @(posedge clk_i);
    end
    // watch for stray strobes once everything is answered
    repeat (DrainWait) @(posedge clk_i);
    if (answer_q.size() > 0) begin
      report_mismatch("answers never delivered", 64'(answer_q.size()), 64'(0));
    end

    $display("covered: %0d inserts, %0d queries, %0d removes, %0d clears; %0d results",
             act_seen[tkrt_pkg::ACT_INSERT], act_seen[tkrt_pkg::ACT_QUERY],
             act_seen[tkrt_pkg::ACT_REMOVE], act_seen[tkrt_pkg::ACT_CLEAR], results_seen);
    $display("covered: %0d key hits, %0d inserts refused when full, peak fill %0d",
             key_hits, full_rejects, peak_count);
    if (mismatches == 0) begin
      $display("two_key_record_table: match");
    end else begin
      $display("two_key_record_table: mismatch");
    end
    $finish;
  end

endmodule

// ===== two_key_record_table.f =====
rtl/core/tkrt_pkg.sv
rtl/core/tkrt_ctrl.sv
rtl/core/tkrt_dp.sv
rtl/core/two_key_record_table.sv
sim/tb_top.sv
